@@ rtl/tdgm_pkg.sv @@
// shared types and constants of the two dimension gas meter
// request and result structs, lane result struct, register and function codes
`timescale 1ns / 1ps
`default_nettype none

package tdgm_pkg;

    localparam int GAS_W     = 32;
    localparam int WIDE_W    = 64;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L2_LIMIT = 8'd0,
        CFG_DA_LIMIT = 8'd1
    } t_cfg_idx;

    localparam logic FUNC_CONSUME = 1'b0;
    localparam logic FUNC_CALL    = 1'b1;

    typedef struct packed {
        logic             func;
        logic [GAS_W-1:0] addr_gas;
        logic [GAS_W-1:0] opcode_l2_gas;
        logic [GAS_W-1:0] da_base_gas;
        logic [GAS_W-1:0] dyn_l2_gas;
        logic [GAS_W-1:0] dyn_da_gas;
        logic [GAS_W-1:0] dyn_l2_factor;
        logic [GAS_W-1:0] dyn_da_factor;
        logic [GAS_W-1:0] alloc_l2;
        logic [GAS_W-1:0] alloc_da;
    } t_in_req;

    typedef struct packed {
        logic              oog_base;
        logic              oog_l2;
        logic              oog_da;
        logic [WIDE_W-1:0] l2_witness;
        logic [WIDE_W-1:0] da_witness;
        logic [GAS_W-1:0]  call_l2_limit;
        logic [GAS_W-1:0]  call_da_limit;
        logic [GAS_W-1:0]  l2_used_now;
        logic [GAS_W-1:0]  da_used_now;
    } t_out_rsp;

    // what one dimension lane found for the request in its second stage
    typedef struct packed {
        logic              over_base;
        logic              over;
        logic [WIDE_W-1:0] witness;
        logic [GAS_W-1:0]  total_lo;
        logic [GAS_W-1:0]  call_limit;
        logic [GAS_W-1:0]  call_witness;
    } t_lane_res;

endpackage

`default_nettype wire

@@ rtl/tdgm_lane.sv @@
// one gas dimension: registered base cost and dynamic product, then checks
// against the used gas and limit; depends on tdgm_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdgm_lane (
    input  wire logic                     i_clk,
    input  wire logic                     i_load,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_base_a,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_base_b,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_dyn,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_factor,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_alloc,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_used,
    input  wire logic [tdgm_pkg::GAS_W-1:0] i_limit,
    output tdgm_pkg::t_lane_res           o_res
);
    import tdgm_pkg::*;

    logic [GAS_W-1:0]  r_base;
    logic [WIDE_W-1:0] r_prod;
    logic [GAS_W-1:0]  r_alloc;

    logic [GAS_W:0]    base_sum;
    logic [WIDE_W-1:0] lim_wide;
    logic [WIDE_W-1:0] total;
    logic [GAS_W-1:0]  left;

    // first stage: base cost wraps at 32 bits, product of the dynamic cost
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base  <= i_base_a + i_base_b;
            r_prod  <= WIDE_W'(i_dyn) * WIDE_W'(i_factor);
            r_alloc <= i_alloc;
        end
    end

    always_comb begin
        base_sum        = {1'b0, i_used} + {1'b0, r_base};
        lim_wide        = WIDE_W'(i_limit);
        total           = WIDE_W'(i_used) + WIDE_W'(r_base) + r_prod;
        o_res.over_base = base_sum > {1'b0, i_limit};
        o_res.over      = total > lim_wide;
        o_res.witness   = o_res.over ? (total - lim_wide - WIDE_W'(1)) : (lim_wide - total);
        o_res.total_lo  = total[GAS_W-1:0];
        // call mode: gas left wraps when used is above the limit
        left = i_limit - i_used;
        if (r_alloc < left) begin
            o_res.call_limit   = r_alloc;
            o_res.call_witness = left - r_alloc - GAS_W'(1);
        end else begin
            o_res.call_limit   = left;
            o_res.call_witness = r_alloc - left;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tdgm_merge.sv @@
// merges the two lanes: out-of-gas flags, commit of used gas, result register
// depends on tdgm_pkg
`timescale 1ns / 1ps
`default_nettype none

module tdgm_merge (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_load,
    input  wire logic                     i_func,
    input  wire tdgm_pkg::t_lane_res      i_l2,
    input  wire tdgm_pkg::t_lane_res      i_da,
    output logic [tdgm_pkg::GAS_W-1:0]    o_l2_used,
    output logic [tdgm_pkg::GAS_W-1:0]    o_da_used,
    output tdgm_pkg::t_out_rsp            o_rsp
);
    import tdgm_pkg::*;

    logic [GAS_W-1:0] r_l2_used, n_l2_used;
    logic [GAS_W-1:0] r_da_used, n_da_used;
    t_out_rsp         r_out, n_out;
    logic             commit;

    always_comb begin
        commit    = (i_func == FUNC_CONSUME) && !i_l2.over_base && !i_da.over_base
                    && !i_l2.over && !i_da.over;
        n_l2_used = commit ? i_l2.total_lo : r_l2_used;
        n_da_used = commit ? i_da.total_lo : r_da_used;

        n_out             = '0;
        n_out.l2_used_now = n_l2_used;
        n_out.da_used_now = n_da_used;
        if (i_func == FUNC_CALL) begin
            n_out.l2_witness    = WIDE_W'(i_l2.call_witness);
            n_out.da_witness    = WIDE_W'(i_da.call_witness);
            n_out.call_l2_limit = i_l2.call_limit;
            n_out.call_da_limit = i_da.call_limit;
        end else begin
            n_out.oog_base   = i_l2.over_base || i_da.over_base;
            n_out.oog_l2     = i_l2.over;
            n_out.oog_da     = i_da.over;
            n_out.l2_witness = i_l2.witness;
            n_out.da_witness = i_da.witness;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_used <= '0;
            r_da_used <= '0;
        end else if (i_load) begin
            r_l2_used <= n_l2_used;
            r_da_used <= n_da_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_l2_used = r_l2_used;
    assign o_da_used = r_da_used;
    assign o_rsp     = r_out;

    a_hold_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load |=> $stable(r_l2_used) && $stable(r_da_used))
        else $error("used gas changed without a request");

    a_no_commit_on_oog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && (n_out.oog_base || n_out.oog_l2 || n_out.oog_da)
        |=> $stable(r_l2_used) && $stable(r_da_used))
        else $error("used gas committed although out of gas");

    a_used_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_out.l2_used_now == r_l2_used && r_out.da_used_now == r_da_used)
        else $error("reported used gas differs from state");

    a_call_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_func == FUNC_CALL
        |=> !r_out.oog_base && !r_out.oog_l2 && !r_out.oog_da && $stable(r_l2_used))
        else $error("call request raised a flag or changed state");

endmodule

`default_nettype wire

@@ rtl/two_dimension_gas_meter.sv @@
// Two dimension gas meter: each request gives exactly one result, and a new request
// is taken every cycle unless the output stalls. The first stage forms the base cost
// and the dynamic cost times factor in one 32x32 multiplier per dimension lane; the
// second stage adds the used gas, compares against the limits, commits the used gas
// if a consume is not out of gas and loads the result register, so a request sees
// the state left by the one before it. Limits are written through the config port at
// any time (ready is always high) and take effect for requests that reach the second
// stage afterwards. Depends on tdgm_pkg, tdgm_lane and tdgm_merge.
`timescale 1ns / 1ps
`default_nettype none

module two_dimension_gas_meter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire tdgm_pkg::t_in_req            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output tdgm_pkg::t_out_rsp                o_out_data,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [tdgm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tdgm_pkg::GAS_W-1:0]   i_cfg_data
);
    import tdgm_pkg::*;

    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_func;
    logic             r_out_valid, n_out_valid;
    logic [GAS_W-1:0] r_l2_limit;
    logic [GAS_W-1:0] r_da_limit;

    logic             out_free;
    logic             in_take;
    logic             s2_load;
    logic [GAS_W-1:0] l2_used;
    logic [GAS_W-1:0] da_used;
    t_lane_res        l2_res;
    t_lane_res        da_res;

    // the result register frees up when empty or taken this cycle
    always_comb begin
        out_free    = !r_out_valid || !i_out_stall;
        s2_load     = r_s1_valid && out_free;
        o_in_stall  = r_s1_valid && !out_free;
        in_take     = i_in_valid && !o_in_stall;
        n_s1_valid  = in_take || (r_s1_valid && !out_free);
        n_out_valid = s2_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_func <= i_in_data.func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_limit <= '0;
            r_da_limit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_L2_LIMIT: begin
                    r_l2_limit <= i_cfg_data;
                end
                CFG_DA_LIMIT: begin
                    r_da_limit <= i_cfg_data;
                end
                default: begin
                    // unknown register, request dropped
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    tdgm_lane u_lane_l2 (
        .i_clk    (i_clk),
        .i_load   (in_take),
        .i_base_a (i_in_data.addr_gas),
        .i_base_b (i_in_data.opcode_l2_gas),
        .i_dyn    (i_in_data.dyn_l2_gas),
        .i_factor (i_in_data.dyn_l2_factor),
        .i_alloc  (i_in_data.alloc_l2),
        .i_used   (l2_used),
        .i_limit  (r_l2_limit),
        .o_res    (l2_res)
    );

    tdgm_lane u_lane_da (
        .i_clk    (i_clk),
        .i_load   (in_take),
        .i_base_a (i_in_data.da_base_gas),
        .i_base_b ('0),
        .i_dyn    (i_in_data.dyn_da_gas),
        .i_factor (i_in_data.dyn_da_factor),
        .i_alloc  (i_in_data.alloc_da),
        .i_used   (da_used),
        .i_limit  (r_da_limit),
        .o_res    (da_res)
    );

    tdgm_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s2_load),
        .i_func    (r_s1_func),
        .i_l2      (l2_res),
        .i_da      (da_res),
        .o_l2_used (l2_used),
        .o_da_used (da_used),
        .o_rsp     (o_out_data)
    );

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
